@@ rtl/mgmf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mgmf_pkg;

  localparam int VALUE_W    = 16;
  localparam int COORD_IN_W = 8;
  localparam int DIM_W      = 9;
  localparam int RAD_W      = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int Q_DEPTH    = 2;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UNKNOWN_CODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT  = 2'd3;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_QUERY,
    OP_ERROR
  } op_kind_t;

  // one classified request between front and back
  typedef struct packed {
    op_kind_t           kind;
    logic [DIM_W-1:0]   cc;
    logic [DIM_W-1:0]   cr;
    logic [DIM_W-1:0]   c0;
    logic [DIM_W-1:0]   c1;
    logic [DIM_W-1:0]   r0;
    logic [DIM_W-1:0]   r1;
    logic [VALUE_W-1:0] value;
  } op_t;

endpackage

`default_nettype wire

@@ rtl/mgmf_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface mgmf_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] col;
  logic [7:0] row;
  logic [15:0] cell_value;

  modport source (output valid, output action, output col, output row, output cell_value,
                  input ready);
  modport sink (input valid, input action, input col, input row, input cell_value,
                output ready);
endinterface

interface mgmf_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] filtered_value;
  logic        coordinate_error;

  modport source (output valid, output filtered_value, output coordinate_error,
                  input ready);
  modport sink (input valid, input filtered_value, input coordinate_error,
                output ready);
endinterface

`default_nettype wire

@@ rtl/mgmf_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mgmf_front
  import mgmf_pkg::*;
#(
  parameter int MAX_COLS   = 256,
  parameter int MAX_ROWS   = 256,
  parameter int MAX_RADIUS = 7
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  mgmf_in_if.sink                    in_ch,
  output logic                       push_valid,
  input  wire logic                  push_ready,
  output op_t                        push_op,
  output logic [VALUE_W-1:0]         unknown_code
);

  localparam int MAX_DIM = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
  localparam int LIM_W   = $clog2(MAX_DIM + 1);
  localparam int SZ_W    = (LIM_W > DIM_W) ? LIM_W : DIM_W;

  logic [RAD_W-1:0] radius;
  logic [DIM_W-1:0] grid_width;
  logic [DIM_W-1:0] grid_height;

  logic [RAD_W-1:0] rad;
  logic [SZ_W-1:0]  w_sat;
  logic [SZ_W-1:0]  h_sat;
  logic [DIM_W-1:0] wv;
  logic [DIM_W-1:0] hv;
  logic [DIM_W-1:0] col9;
  logic [DIM_W-1:0] row9;
  logic [DIM_W-1:0] rad9;
  logic [DIM_W-1:0] col_hi;
  logic [DIM_W-1:0] row_hi;
  logic             in_grid;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius       <= RAD_W'(1);
      unknown_code <= VALUE_W'(65535);
      grid_width   <= DIM_W'(256);
      grid_height  <= DIM_W'(256);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RADIUS:       radius       <= cfg_data[RAD_W-1:0];
        REG_UNKNOWN_CODE: unknown_code <= cfg_data[VALUE_W-1:0];
        REG_GRID_WIDTH:   grid_width   <= cfg_data[DIM_W-1:0];
        REG_GRID_HEIGHT:  grid_height  <= cfg_data[DIM_W-1:0];
      endcase
    end
  end

  always_comb begin
    rad   = (int'(radius) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : radius;
    w_sat = (SZ_W'(grid_width) > SZ_W'(MAX_COLS)) ? SZ_W'(MAX_COLS) : SZ_W'(grid_width);
    h_sat = (SZ_W'(grid_height) > SZ_W'(MAX_ROWS)) ? SZ_W'(MAX_ROWS) : SZ_W'(grid_height);
    wv    = w_sat[DIM_W-1:0];
    hv    = h_sat[DIM_W-1:0];
    col9  = DIM_W'(in_ch.col);
    row9  = DIM_W'(in_ch.row);
    rad9  = DIM_W'(rad);
    col_hi = col9 + rad9;
    row_hi = row9 + rad9;
    in_grid = (col9 < wv) && (row9 < hv);

    push_op.cc    = col9;
    push_op.cr    = row9;
    push_op.c0    = (col9 >= rad9) ? col9 - rad9 : '0;
    push_op.r0    = (row9 >= rad9) ? row9 - rad9 : '0;
    push_op.c1    = (col_hi < wv) ? col_hi : wv - DIM_W'(1);
    push_op.r1    = (row_hi < hv) ? row_hi : hv - DIM_W'(1);
    push_op.value = in_ch.cell_value;

    // writes outside the grid are dropped here
    if (in_ch.action == ACT_WRITE) begin
      push_op.kind = OP_WRITE;
      push_valid   = in_ch.valid && in_grid;
    end else begin
      push_op.kind = in_grid ? OP_QUERY : OP_ERROR;
      push_valid   = in_ch.valid;
    end
  end

  assign in_ch.ready = push_ready;

endmodule

`default_nettype wire

@@ rtl/mgmf_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mgmf_queue
  import mgmf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push_valid,
  output logic      push_ready,
  input  wire op_t  push_op,
  output logic      pop_valid,
  input  wire logic pop_ready,
  output op_t       pop_op
);

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  op_t              entries [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(Q_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_op     = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/mgmf_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mgmf_back
  import mgmf_pkg::*;
#(
  parameter int MAX_COLS   = 256,
  parameter int MAX_ROWS   = 256,
  parameter int VALUE_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               pop_valid,
  output logic                    pop_ready,
  input  wire op_t                pop_op,
  input  wire logic [VALUE_W-1:0] unknown_code,
  mgmf_out_if.source              out_ch
);

  localparam int DEPTH  = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W = $clog2(DEPTH);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_CENTRE = 2'd1;
  localparam logic [1:0] ST_SCAN   = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd3;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [DIM_W-1:0] c,
                                                input logic [DIM_W-1:0] r);
    addr_of = ADDR_W'(r * MAX_COLS) + ADDR_W'(c);
  endfunction

  logic [VALUE_BITS-1:0] mem [DEPTH];
  logic [VALUE_BITS-1:0] rd_data;
  logic                  mem_we;
  logic                  mem_re;
  logic [ADDR_W-1:0]     waddr;
  logic [ADDR_W-1:0]     raddr;

  logic [1:0]            state;
  logic [DIM_W-1:0]      c0;
  logic [DIM_W-1:0]      c1;
  logic [DIM_W-1:0]      r0;
  logic [DIM_W-1:0]      r1;
  logic [DIM_W-1:0]      c;
  logic [DIM_W-1:0]      r;
  logic [VALUE_BITS-1:0] best;
  logic                  issue_done;
  logic                  pend;
  logic                  out_valid;
  logic [VALUE_W-1:0]    out_value;
  logic                  out_err;

  logic                  out_free;
  logic [VALUE_BITS-1:0] unk;
  logic                  take;
  logic                  out_load;

  assign out_free = !out_valid || out_ch.ready;
  assign unk      = VALUE_BITS'(unknown_code);
  assign take     = pop_valid && pop_ready;
  assign out_load = (state == ST_IDLE && take && pop_op.kind == OP_ERROR) ||
                    (state == ST_DONE && out_free);

  always_comb begin
    pop_ready = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    waddr     = addr_of(pop_op.cc, pop_op.cr);
    raddr     = addr_of(c, r);
    if (state == ST_IDLE && pop_valid) begin
      unique case (pop_op.kind)
        OP_WRITE: begin
          pop_ready = 1'b1;
          mem_we    = 1'b1;
        end
        OP_QUERY: begin
          pop_ready = 1'b1;
          mem_re    = 1'b1;
          raddr     = addr_of(pop_op.cc, pop_op.cr);
        end
        OP_ERROR: pop_ready = out_free;
        default:  pop_ready = 1'b1;
      endcase
    end
    if (state == ST_SCAN && !issue_done) begin
      mem_re = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= VALUE_BITS'(pop_op.value);
    end
    if (mem_re) begin
      rd_data <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      issue_done <= 1'b0;
      pend       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (take && pop_op.kind == OP_QUERY) begin
            c0    <= pop_op.c0;
            c1    <= pop_op.c1;
            r0    <= pop_op.r0;
            r1    <= pop_op.r1;
            state <= ST_CENTRE;
          end
          if (take && pop_op.kind == OP_ERROR) begin
            out_value <= '0;
            out_err   <= 1'b1;
          end
        end
        ST_CENTRE: begin
          best       <= rd_data;
          c          <= c0;
          r          <= r0;
          issue_done <= 1'b0;
          pend       <= 1'b0;
          // unknown centre returns the code as it is
          state      <= (rd_data == unk) ? ST_DONE : ST_SCAN;
        end
        ST_SCAN: begin
          if (pend && rd_data != unk && rd_data < best) begin
            best <= rd_data;
          end
          if (!issue_done) begin
            pend <= 1'b1;
            if (r == r1) begin
              r <= r0;
              if (c == c1) begin
                issue_done <= 1'b1;
              end else begin
                c <= c + DIM_W'(1);
              end
            end else begin
              r <= r + DIM_W'(1);
            end
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              state <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_value <= VALUE_W'(best);
            out_err   <= 1'b0;
            state     <= ST_IDLE;
          end
        end
      endcase
    end
  end

  assign out_ch.valid            = out_valid;
  assign out_ch.filtered_value   = out_value;
  assign out_ch.coordinate_error = out_err;

endmodule

`default_nettype wire

@@ rtl/masked_grid_min_filter_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Masked grid erosion. A write request stores one cell in a single-port-read
// memory of MAX_COLS*MAX_ROWS entries in the back end; a write outside the
// grid in use is dropped at the front. A query inside the grid reads the
// centre cell and, unless it is unknown, reads each window cell in turn, then
// drains the read pipeline and loads the result; an unknown centre skips the
// scan. A query outside the grid returns an error.
// The back end's memory read port, one read per window cell, limits query
// time. A two-entry request queue lets the input side keep accepting while a
// query runs, until the queue fills, and the result register holds a finished
// result until it is taken. The cell store is not cleared at reset: a cell
// read before it was written returns an undefined value.
module masked_grid_min_filter_unit
  import mgmf_pkg::*;
#(
  parameter int MAX_COLS   = 256,
  parameter int MAX_ROWS   = 256,
  parameter int MAX_RADIUS = 7,
  parameter int VALUE_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  mgmf_in_if.sink                    in_ch,
  mgmf_out_if.source                 out_ch
);

  logic               q_push_valid;
  logic               q_push_ready;
  op_t                q_push_op;
  logic               q_pop_valid;
  logic               q_pop_ready;
  op_t                q_pop_op;
  logic [VALUE_W-1:0] unknown_code;

  mgmf_front #(
    .MAX_COLS  (MAX_COLS),
    .MAX_ROWS  (MAX_ROWS),
    .MAX_RADIUS(MAX_RADIUS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_ch       (in_ch),
    .push_valid  (q_push_valid),
    .push_ready  (q_push_ready),
    .push_op     (q_push_op),
    .unknown_code(unknown_code)
  );

  mgmf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(q_push_valid),
    .push_ready(q_push_ready),
    .push_op   (q_push_op),
    .pop_valid (q_pop_valid),
    .pop_ready (q_pop_ready),
    .pop_op    (q_pop_op)
  );

  mgmf_back #(
    .MAX_COLS  (MAX_COLS),
    .MAX_ROWS  (MAX_ROWS),
    .VALUE_BITS(VALUE_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .pop_valid   (q_pop_valid),
    .pop_ready   (q_pop_ready),
    .pop_op      (q_pop_op),
    .unknown_code(unknown_code),
    .out_ch      (out_ch)
  );

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_ch.valid && !q_pop_valid)
    else $error("result or request pending after reset");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.coordinate_error |-> out_ch.filtered_value == '0)
    else $error("flagged result carries a value");

  a_full_has_head: assert property (@(posedge clk) disable iff (rst)
    !q_push_ready |-> q_pop_valid)
    else $error("request queue full but empty at head");

endmodule

`default_nettype wire

@@ test/mgmf_checker.sv @@
`timescale 1ns / 1ps

module mgmf_checker
  import mgmf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  in_action,
  input  logic [7:0]            in_col,
  input  logic [7:0]            in_row,
  input  logic [15:0]           in_cell_value,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [15:0]           out_filtered_value,
  input  logic                  out_coordinate_error,
  output int                    pending,
  output int                    mismatches
);

  localparam int GRID_COLS = 256;
  localparam int GRID_ROWS = 256;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               coord_err;
  } erosion_t;

  logic [VALUE_W-1:0] cell_store [GRID_COLS*GRID_ROWS];
  logic [RAD_W-1:0]   radius_q;
  logic [VALUE_W-1:0] unknown_q;
  logic [DIM_W-1:0]   width_q;
  logic [DIM_W-1:0]   height_q;
  erosion_t           erosion_q [$];

  initial mismatches = 0;

  function automatic int cols_in_use();
    return (width_q > GRID_COLS) ? GRID_COLS : int'(width_q);
  endfunction

  function automatic int rows_in_use();
    return (height_q > GRID_ROWS) ? GRID_ROWS : int'(height_q);
  endfunction

  function automatic erosion_t erode(int col, int row);
    erosion_t res;
    int w, h, rad, c0, c1, r0, r1;
    logic [VALUE_W-1:0] best, v;
    w = cols_in_use();
    h = rows_in_use();
    rad = int'(radius_q);
    res.value = '0;
    res.coord_err = 1'b1;
    if (col >= w || row >= h) begin
      return res;
    end
    best = cell_store[row*GRID_COLS + col];
    if (best != unknown_q) begin
      c0 = (col >= rad) ? col - rad : 0;
      c1 = (col + rad < w) ? col + rad : w - 1;
      r0 = (row >= rad) ? row - rad : 0;
      r1 = (row + rad < h) ? row + rad : h - 1;
      for (int c = c0; c <= c1; c++) begin
        for (int r = r0; r <= r1; r++) begin
          v = cell_store[r*GRID_COLS + c];
          if (v != unknown_q && v < best) begin
            best = v;
          end
        end
      end
    end
    res.value = best;
    res.coord_err = 1'b0;
    return res;
  endfunction

  task automatic report(string what, int got, int want);
    $display("%0t: %s got %0h expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    erosion_t want;
    if (rst) begin
      radius_q = 3'd1;
      unknown_q = 16'hFFFF;
      width_q = 9'd256;
      height_q = 9'd256;
      erosion_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_RADIUS:       radius_q = cfg_data[RAD_W-1:0];
          REG_UNKNOWN_CODE: unknown_q = cfg_data[VALUE_W-1:0];
          REG_GRID_WIDTH:   width_q = cfg_data[DIM_W-1:0];
          REG_GRID_HEIGHT:  height_q = cfg_data[DIM_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (in_action == ACT_WRITE) begin
          if (int'(in_col) < cols_in_use() && int'(in_row) < rows_in_use()) begin
            cell_store[int'(in_row)*GRID_COLS + int'(in_col)] = in_cell_value;
          end
        end else begin
          erosion_q.push_back(erode(int'(in_col), int'(in_row)));
        end
      end
      if (out_valid && out_ready) begin
        if (erosion_q.size() == 0) begin
          report("result with no query outstanding, value", out_filtered_value, 0);
        end else begin
          want = erosion_q.pop_front();
          if (out_filtered_value !== want.value) begin
            report("filtered_value", out_filtered_value, want.value);
          end
          if (out_coordinate_error !== want.coord_err) begin
            report("coordinate_error", out_coordinate_error, want.coord_err);
          end
        end
      end
    end
    pending <= erosion_q.size();
  end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import mgmf_pkg::*;

  localparam int SETTLE_CYCLES = 32;
  localparam int ITEM_TARGET   = 1200;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    pending;
  int                    mismatches;

  mgmf_in_if  in_ch ();
  mgmf_out_if out_ch ();

  masked_grid_min_filter_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  mgmf_checker i_checker (
    .clk                  (clk),
    .rst                  (rst),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_valid             (in_ch.valid),
    .in_ready             (in_ch.ready),
    .in_action            (in_ch.action),
    .in_col               (in_ch.col),
    .in_row               (in_ch.row),
    .in_cell_value        (in_ch.cell_value),
    .out_valid            (out_ch.valid),
    .out_ready            (out_ch.ready),
    .out_filtered_value   (out_ch.filtered_value),
    .out_coordinate_error (out_ch.coordinate_error),
    .pending              (pending),
    .mismatches           (mismatches)
  );

  // cells written since power-up, by absolute address
  bit          written [256*256];
  int          rad_now;
  logic [15:0] unk_now;
  int          w_now;
  int          h_now;
  int          burst_left;
  int          sent;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int hold;
    int pick;
    hold = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold == 0) begin
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          out_ch.ready <= 1'b1;
          hold = (pick == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
        end else begin
          out_ch.ready <= 1'b0;
          hold = $urandom_range(1, 15);
        end
      end else begin
        hold--;
      end
    end
  end

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1: return unk_now;
      2: return 16'h0000;
      3: return 16'hFFFF;
      4: return unk_now + 16'($urandom_range(0, 2)) - 16'd1;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pad_field(int v, int bits);
    logic [CFG_DATA_W-1:0] junk;
    junk = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom) : '0;
    return (junk << bits) | CFG_DATA_W'(v);
  endfunction

  task automatic send_item(logic act, int col, int row, logic [15:0] value);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    burst_left--;
    in_ch.valid      <= 1'b1;
    in_ch.action     <= act;
    in_ch.col        <= col[7:0];
    in_ch.row        <= row[7:0];
    in_ch.cell_value <= value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (col < w_now && row < h_now) begin
      if (act == ACT_WRITE) begin
        written[row*256 + col] = 1'b1;
      end
      sent++;
    end else if (act == ACT_QUERY) begin
      sent++;
    end
  endtask

  // fills any unwritten cell of the window first so no stale cell is read
  task automatic query_cell(int col, int row);
    if (col < w_now && row < h_now) begin
      for (int c = (col > rad_now ? col - rad_now : 0);
           c <= (col + rad_now < w_now ? col + rad_now : w_now - 1); c++) begin
        for (int r = (row > rad_now ? row - rad_now : 0);
             r <= (row + rad_now < h_now ? row + rad_now : h_now - 1); r++) begin
          if (!written[r*256 + c]) begin
            send_item(ACT_WRITE, c, r, pick_value());
          end
        end
      end
    end
    send_item(ACT_QUERY, col, row, 16'($urandom));
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(int rad, logic [15:0] unk, int w, int h);
    logic [CFG_IDX_W-1:0]  idx  [4];
    logic [CFG_DATA_W-1:0] vals [4];
    idx[0]  = REG_RADIUS;
    idx[1]  = REG_UNKNOWN_CODE;
    idx[2]  = REG_GRID_WIDTH;
    idx[3]  = REG_GRID_HEIGHT;
    vals[0] = pad_field(rad, RAD_W);
    vals[1] = pad_field(int'(unk), VALUE_W);
    vals[2] = pad_field(w, DIM_W);
    vals[3] = pad_field(h, DIM_W);
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_we  <= 1'b0;
    rad_now = rad;
    unk_now = unk;
    w_now   = (w > 256) ? 256 : w;
    h_now   = (h > 256) ? 256 : h;
  endtask

  initial begin
    int rad, w, h, n, k, c, r, base_c, base_r;
    logic [15:0] unk;
    logic can_out;

    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_index        <= REG_RADIUS;
    cfg_data         <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.action     <= ACT_WRITE;
    in_ch.col        <= '0;
    in_ch.row        <= '0;
    in_ch.cell_value <= '0;
    rad_now    = 1;
    unk_now    = 16'hFFFF;
    w_now      = 256;
    h_now      = 256;
    burst_left = 0;
    sent       = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // settings straight out of reset
    send_item(ACT_WRITE, 0, 0, 16'h8000);
    send_item(ACT_WRITE, 1, 0, 16'h9000);
    send_item(ACT_WRITE, 0, 1, 16'h4000);
    send_item(ACT_WRITE, 1, 1, 16'hFFFF);
    query_cell(0, 0);
    send_item(ACT_WRITE, 255, 255, 16'h0000);
    send_item(ACT_WRITE, 254, 255, 16'h7777);
    send_item(ACT_WRITE, 255, 254, 16'hFFFF);
    send_item(ACT_WRITE, 254, 254, 16'h2222);
    query_cell(255, 255);
    // unknown centre reads only itself
    send_item(ACT_WRITE, 100, 100, 16'hFFFF);
    send_item(ACT_QUERY, 100, 100, 16'h0000);

    // no column in use
    settle();
    apply_settings(0, 16'h0000, 0, 5);
    send_item(ACT_WRITE, 0, 0, 16'h0001);
    send_item(ACT_QUERY, 0, 0, 16'h0000);

    // oversize grid saturates
    settle();
    apply_settings(0, 16'hFFFF, 511, 300);
    query_cell(255, 255);
    query_cell(254, 255);

    // widest window clipped to a tiny grid, zero marks unknown
    settle();
    apply_settings(7, 16'h0000, 3, 2);
    query_cell(1, 1);
    send_item(ACT_WRITE, 2, 2, 16'h1111);
    send_item(ACT_QUERY, 3, 0, 16'h0000);
    send_item(ACT_QUERY, 0, 2, 16'h0000);

    while (sent < ITEM_TARGET) begin
      settle();
      rad = $urandom_range(0, 7);
      case ($urandom_range(0, 3))
        0: unk = 16'hFFFF;
        1: unk = 16'h0000;
        default: unk = 16'($urandom);
      endcase
      case ($urandom_range(0, 9))
        0: begin
          w = $urandom_range(0, 1) ? 256 : $urandom_range(256, 511);
          h = $urandom_range(0, 1) ? 256 : $urandom_range(256, 511);
        end
        1: begin
          w = $urandom_range(0, 1) ? 0 : $urandom_range(1, 256);
          h = (w == 0) ? $urandom_range(0, 256) : 0;
        end
        default: begin
          w = $urandom_range(1, 16);
          h = $urandom_range(1, 16);
        end
      endcase
      apply_settings(rad, unk, w, h);
      case ($urandom_range(0, 2))
        0: base_c = 0;
        1: base_c = 248;
        default: base_c = $urandom_range(0, 248);
      endcase
      case ($urandom_range(0, 2))
        0: base_r = 0;
        1: base_r = 248;
        default: base_r = $urandom_range(0, 248);
      endcase
      can_out = (w_now < 256 || h_now < 256);
      n = $urandom_range(30, 100);
      repeat (n) begin
        k = $urandom_range(0, 19);
        if (can_out && (k < 4 || w_now == 0 || h_now == 0)) begin
          if (w_now < 256) begin
            c = $urandom_range(w_now, 255);
            r = $urandom_range(0, 255);
          end else begin
            c = $urandom_range(0, 255);
            r = $urandom_range(h_now, 255);
          end
          if (k < 2) begin
            send_item(ACT_WRITE, c, r, pick_value());
          end else begin
            send_item(ACT_QUERY, c, r, 16'($urandom));
          end
        end else begin
          c = (w_now > 16) ? base_c + $urandom_range(0, 7) : $urandom_range(0, w_now - 1);
          r = (h_now > 16) ? base_r + $urandom_range(0, 7) : $urandom_range(0, h_now - 1);
          if (k < 10) begin
            send_item(ACT_WRITE, c, r, pick_value());
          end else begin
            query_cell(c, r);
          end
        end
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
